/* design/pidpm_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the position PID motor drive.
// Used by pidpm_ctrl, pidpm_datapath and pid_position_motor_drive.
package pidpm_pkg;

   // Default number format: Q16.16 in a 32-bit signed word
   localparam int DATA_WIDTH_DEF  = 32;
   localparam int FRAC_BITS_DEF   = 16;

   // Fixed field widths
   localparam int IN_WIDTH        = 32;
   localparam int CFG_WIDTH       = 31;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int PWM_MAX         = 255;

   // Control and status register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAIN_PROP      = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAIN_INTEGRAL  = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAIN_DERIV     = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SAMPLE_PERIOD  = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INVERSE_PERIOD = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INTEGRAL_LIMIT = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_EFFORT_TO_PWM  = 3'd6;

   // Register reset values
   localparam logic [CFG_WIDTH-1:0] RST_GAIN_PROP      = 31'd0;
   localparam logic [CFG_WIDTH-1:0] RST_GAIN_INTEGRAL  = 31'd0;
   localparam logic [CFG_WIDTH-1:0] RST_GAIN_DERIV     = 31'd0;
   localparam logic [CFG_WIDTH-1:0] RST_SAMPLE_PERIOD  = 31'd328;
   localparam logic [CFG_WIDTH-1:0] RST_INVERSE_PERIOD = 31'd13107200;
   localparam logic [CFG_WIDTH-1:0] RST_INTEGRAL_LIMIT = 31'd2147483647;
   localparam logic [CFG_WIDTH-1:0] RST_EFFORT_TO_PWM  = 31'd2088960;

   // Product sequence, one entry per use of the shared multiplier
   typedef enum logic [2:0] {
      OP_INTEG = 3'd0,   // error * sample period
      OP_DERIV = 3'd1,   // measurement step * inverse period
      OP_PROP  = 3'd2,   // error * proportional gain
      OP_IGAIN = 3'd3,   // integral * integral gain
      OP_DGAIN = 3'd4,   // derivative * derivative gain
      OP_PWM   = 3'd5    // effort * PWM scale
   } op_type;

   // Controller states, one-hot
   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_LOAD  = 8'b0000_0010,
      S_SETUP = 8'b0000_0100,
      S_LO    = 8'b0000_1000,
      S_HI    = 8'b0001_0000,
      S_ACC   = 8'b0010_0000,
      S_CAP   = 8'b0100_0000,
      S_WB    = 8'b1000_0000
   } state_type;

   typedef struct packed {
      logic signed [IN_WIDTH-1:0] setpoint;
      logic signed [IN_WIDTH-1:0] measured;
   } req_payload_type;

   typedef struct packed {
      logic signed [8:0] drive_effort;
      logic [7:0]        forward_duty;
      logic [7:0]        reverse_duty;
   } rsp_payload_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic   capture;
      logic   load;
      logic   setup;
      logic   mul_lo;
      logic   mul_hi;
      logic   mul_acc;
      logic   cap;
      logic   wb;
      op_type op;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic out_busy;
   } status_type;

endpackage

/* design/pidpm_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer for the PID drive: steps the datapath through six products.
// Depends on pidpm_pkg.
module pidpm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output pidpm_pkg::cmd_type    cmd,
   input  pidpm_pkg::status_type status
);
   import pidpm_pkg::*;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;

   // Take a request only between items
   assign req_ready = (state_ff == S_IDLE);

   // Next state and command decode
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      cmd      = '0;
      cmd.op   = op_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_LOAD;
            end
         end
         S_LOAD: begin
            cmd.load = 1'b1;
            op_in    = OP_INTEG;
            state_in = S_SETUP;
         end
         S_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = S_LO;
         end
         S_LO: begin
            cmd.mul_lo = 1'b1;
            state_in   = S_HI;
         end
         S_HI: begin
            cmd.mul_hi = 1'b1;
            state_in   = S_ACC;
         end
         S_ACC: begin
            cmd.mul_acc = 1'b1;
            state_in    = S_CAP;
         end
         S_CAP: begin
            cmd.cap  = 1'b1;
            state_in = S_WB;
         end
         S_WB: begin
            if (op_ff == OP_PWM) begin
               // hold the last write-back until the result register frees up
               if (!status.out_busy) begin
                  cmd.wb   = 1'b1;
                  state_in = S_IDLE;
               end
            end else begin
               cmd.wb   = 1'b1;
               op_in    = op_type'(op_ff + 3'd1);
               state_in = S_SETUP;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff    <= OP_INTEG;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   // An accepted request starts the load step
   a_accept_load: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_LOAD))
      else $error("accepted request did not start the load step");

   // Product sequence restarts at the integral step
   a_load_first_op: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOAD) |=> (op_ff == OP_INTEG))
      else $error("product sequence did not restart");

   // A stalled result holds the final write-back
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WB && op_ff == OP_PWM && status.out_busy) |=> (state_ff == S_WB))
      else $error("final write-back left while the result register was full");

endmodule

/* design/pidpm_datapath.sv */
`timescale 1ns / 1ps
// Datapath for the PID drive: CSRs, loop state, shared split multiplier,
// saturation and the result register. Depends on pidpm_pkg.
module pidpm_datapath #(
   parameter int DATA_WIDTH = pidpm_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = pidpm_pkg::FRAC_BITS_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     csr_valid,
   input  logic [pidpm_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [pidpm_pkg::CFG_WIDTH-1:0]          csr_wdata,
   input  pidpm_pkg::req_payload_type               req_data,
   input  pidpm_pkg::cmd_type                       cmd,
   output pidpm_pkg::status_type                    status,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output pidpm_pkg::rsp_payload_type               rsp_data
);
   import pidpm_pkg::*;

   localparam int DW  = DATA_WIDTH;
   localparam int HW  = (DW + 1) / 2;                     // low half of a magnitude
   localparam int PPW = HW + CFG_WIDTH;                   // partial product
   localparam int PW  = DW + CFG_WIDTH;                   // full product
   localparam int EW  = (DW > IN_WIDTH) ? DW : IN_WIDTH;  // input compare width
   localparam int SW  = DW + 2;                           // sums of up to three terms
   localparam logic [DW-1:0]        MAX_U = {1'b0, {(DW-1){1'b1}}};
   localparam logic signed [DW-1:0] MAX_S = {1'b0, {(DW-1){1'b1}}};
   localparam logic signed [DW-1:0] MIN_S = {1'b1, {(DW-1){1'b0}}};

   // Saturate a 32-bit input to the data range
   function automatic logic signed [DW-1:0] sat_in(input logic signed [IN_WIDTH-1:0] v);
      logic signed [EW-1:0] x;
      logic signed [DW-1:0] r;
      x = EW'(v);
      if (x > EW'(MAX_S)) begin
         r = MAX_S;
      end else if (x < EW'(MIN_S)) begin
         r = MIN_S;
      end else begin
         r = x[DW-1:0];
      end
      return r;
   endfunction

   // Saturate a widened sum to the data range
   function automatic logic signed [DW-1:0] sat_sum(input logic signed [SW-1:0] v);
      logic signed [DW-1:0] r;
      if (v > SW'(MAX_S)) begin
         r = MAX_S;
      end else if (v < SW'(MIN_S)) begin
         r = MIN_S;
      end else begin
         r = v[DW-1:0];
      end
      return r;
   endfunction

   // CSRs
   logic [CFG_WIDTH-1:0] gain_prop_ff, gain_integral_ff, gain_deriv_ff;
   logic [CFG_WIDTH-1:0] sample_period_ff, inverse_period_ff;
   logic [CFG_WIDTH-1:0] integral_limit_ff, effort_to_pwm_ff;
   logic [CFG_WIDTH-1:0] gain_prop_in, gain_integral_in, gain_deriv_in;
   logic [CFG_WIDTH-1:0] sample_period_in, inverse_period_in;
   logic [CFG_WIDTH-1:0] integral_limit_in, effort_to_pwm_in;

   // Loop state and working registers
   logic signed [DW-1:0] integ_ff, integ_in, prev_ff, prev_in;
   logic signed [DW-1:0] sp_ff, sp_in, ms_ff, ms_in;
   logic signed [DW-1:0] e_ff, e_in, dm_ff, dm_in, de_ff, de_in;
   logic signed [SW-1:0] sum_ff, sum_in;

   // Multiplier registers
   logic                 neg_ff, neg_in;
   logic [DW-1:0]        mag_ff, mag_in;
   logic [CFG_WIDTH-1:0] b_ff, b_in;
   logic [PPW-1:0]       pp_ff, pp_in;
   logic [PW-1:0]        acc_ff, acc_in;
   logic [DW-1:0]        r_ff, r_in;

   // Result register
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   // Combinational helpers
   logic signed [DW-1:0] a_sel;
   logic [CFG_WIDTH-1:0] b_sel;
   logic [HW-1:0]        mul_a;
   logic [PW-1:0]        shifted, cap_val;
   logic signed [DW:0]   sv;
   logic [DW-1:0]        lim_u;
   logic signed [DW-1:0] lim_s, integ_sat;

   // CSR writes; an index past the list is ignored
   always_comb begin
      gain_prop_in      = gain_prop_ff;
      gain_integral_in  = gain_integral_ff;
      gain_deriv_in     = gain_deriv_ff;
      sample_period_in  = sample_period_ff;
      inverse_period_in = inverse_period_ff;
      integral_limit_in = integral_limit_ff;
      effort_to_pwm_in  = effort_to_pwm_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_GAIN_PROP:      gain_prop_in      = csr_wdata;
            CSR_GAIN_INTEGRAL:  gain_integral_in  = csr_wdata;
            CSR_GAIN_DERIV:     gain_deriv_in     = csr_wdata;
            CSR_SAMPLE_PERIOD:  sample_period_in  = csr_wdata;
            CSR_INVERSE_PERIOD: inverse_period_in = csr_wdata;
            CSR_INTEGRAL_LIMIT: integral_limit_in = csr_wdata;
            CSR_EFFORT_TO_PWM:  effort_to_pwm_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   // Pick the operands of the next product
   always_comb begin
      case (cmd.op)
         OP_INTEG: begin a_sel = e_ff;             b_sel = sample_period_ff;  end
         OP_DERIV: begin a_sel = dm_ff;            b_sel = inverse_period_ff; end
         OP_PROP:  begin a_sel = e_ff;             b_sel = gain_prop_ff;      end
         OP_IGAIN: begin a_sel = integ_ff;         b_sel = gain_integral_ff;  end
         OP_DGAIN: begin a_sel = de_ff;            b_sel = gain_deriv_ff;     end
         OP_PWM:   begin a_sel = sat_sum(sum_ff);  b_sel = effort_to_pwm_ff;  end
         default:  begin a_sel = '0;               b_sel = '0;                end
      endcase
   end

   // Shared multiplier takes the low half, then the high half
   assign mul_a = cmd.mul_hi ? HW'(mag_ff[DW-1:HW]) : mag_ff[HW-1:0];

   // Drop fraction bits and cap the magnitude
   assign shifted = (cmd.op == OP_PWM) ? (acc_ff >> (2 * FRAC_BITS)) : (acc_ff >> FRAC_BITS);
   assign cap_val = (cmd.op == OP_PWM) ? PW'(PWM_MAX) : (PW'(MAX_U) + PW'(neg_ff));

   // Signed result of the finished product
   assign sv = neg_ff ? -$signed({1'b0, r_ff}) : $signed({1'b0, r_ff});

   // Integral limit, capped to the data range
   always_comb begin
      lim_u = (EW'(integral_limit_ff) > EW'(MAX_U)) ? MAX_U : DW'(integral_limit_ff);
      lim_s = $signed(lim_u);
      integ_sat = sat_sum(SW'(integ_ff) + SW'(sv));
   end

   // Datapath next values
   always_comb begin
      sp_in    = sp_ff;
      ms_in    = ms_ff;
      e_in     = e_ff;
      dm_in    = dm_ff;
      de_in    = de_ff;
      prev_in  = prev_ff;
      integ_in = integ_ff;
      sum_in   = sum_ff;
      neg_in   = neg_ff;
      mag_in   = mag_ff;
      b_in     = b_ff;
      pp_in    = pp_ff;
      acc_in   = acc_ff;
      r_in     = r_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;

      // capture saturated inputs
      if (cmd.capture) begin
         sp_in = sat_in(req_data.setpoint);
         ms_in = sat_in(req_data.measured);
      end

      // form error and measurement step, advance the last measurement
      if (cmd.load) begin
         e_in    = sat_sum(SW'(sp_ff) - SW'(ms_ff));
         dm_in   = sat_sum(SW'(prev_ff) - SW'(ms_ff));
         prev_in = ms_ff;
      end

      // split the operand into sign and magnitude
      if (cmd.setup) begin
         neg_in = a_sel[DW-1];
         mag_in = a_sel[DW-1] ? $unsigned(-a_sel) : $unsigned(a_sel);
         b_in   = b_sel;
      end

      // partial products and their sum
      if (cmd.mul_lo || cmd.mul_hi) begin
         pp_in = PPW'(mul_a) * PPW'(b_ff);
      end
      if (cmd.mul_hi) begin
         acc_in = PW'(pp_ff);
      end
      if (cmd.mul_acc) begin
         acc_in = acc_ff + (PW'(pp_ff) << HW);
      end

      // truncate toward zero and saturate the magnitude
      if (cmd.cap) begin
         r_in = (shifted > cap_val) ? DW'(cap_val) : shifted[DW-1:0];
      end

      // write the product back where it belongs
      if (cmd.wb) begin
         case (cmd.op)
            OP_INTEG: begin
               if (integ_sat > lim_s) begin
                  integ_in = lim_s;
               end else if (integ_sat < -lim_s) begin
                  integ_in = -lim_s;
               end else begin
                  integ_in = integ_sat;
               end
            end
            OP_DERIV: de_in  = sv[DW-1:0];
            OP_PROP:  sum_in = SW'(sv);
            OP_IGAIN: sum_in = sum_ff + SW'(sv);
            OP_DGAIN: sum_in = sum_ff + SW'(sv);
            OP_PWM: begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.drive_effort  = sv[8:0];
               if (!neg_ff && r_ff != '0) begin
                  rsp_data_in.forward_duty = r_ff[7:0];
                  rsp_data_in.reverse_duty = 8'd0;
               end else begin
                  rsp_data_in.forward_duty = 8'd0;
                  rsp_data_in.reverse_duty = r_ff[7:0];
               end
            end
            default: ;
         endcase
      end
   end

   // Control state: CSRs, loop state, result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_prop_ff      <= RST_GAIN_PROP;
         gain_integral_ff  <= RST_GAIN_INTEGRAL;
         gain_deriv_ff     <= RST_GAIN_DERIV;
         sample_period_ff  <= RST_SAMPLE_PERIOD;
         inverse_period_ff <= RST_INVERSE_PERIOD;
         integral_limit_ff <= RST_INTEGRAL_LIMIT;
         effort_to_pwm_ff  <= RST_EFFORT_TO_PWM;
         integ_ff          <= '0;
         prev_ff           <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         gain_prop_ff      <= gain_prop_in;
         gain_integral_ff  <= gain_integral_in;
         gain_deriv_ff     <= gain_deriv_in;
         sample_period_ff  <= sample_period_in;
         inverse_period_ff <= inverse_period_in;
         integral_limit_ff <= integral_limit_in;
         effort_to_pwm_ff  <= effort_to_pwm_in;
         integ_ff          <= integ_in;
         prev_ff           <= prev_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      sp_ff       <= sp_in;
      ms_ff       <= ms_in;
      e_ff        <= e_in;
      dm_ff       <= dm_in;
      de_ff       <= de_in;
      sum_ff      <= sum_in;
      neg_ff      <= neg_in;
      mag_ff      <= mag_in;
      b_ff        <= b_in;
      pp_ff       <= pp_in;
      acc_ff      <= acc_in;
      r_ff        <= r_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign status.out_busy = rsp_valid_ff & ~rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;

   // Only one bridge channel drives at a time
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.forward_duty == 8'd0 || rsp_data_ff.reverse_duty == 8'd0))
      else $error("both bridge channels driven");

   // Drive command never reaches -256
   a_drive_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.drive_effort[8] == 1'b0 ||
                        rsp_data_ff.drive_effort[7:0] != 8'd0))
      else $error("drive effort out of range");

   // PWM magnitude is capped at full duty
   a_pwm_cap: assert property (@(posedge clock) disable iff (reset)
      (cmd.cap && cmd.op == OP_PWM) |=> (r_ff <= DW'(PWM_MAX)))
      else $error("PWM magnitude above full duty");

endmodule

/* design/pid_position_motor_drive.sv */
`timescale 1ns / 1ps
// Top level of the position PID motor drive with anti-windup and H-bridge split.
// Depends on pidpm_pkg, pidpm_ctrl and pidpm_datapath.
//
// Usage:
//   req_*  : one request carries a setpoint and a measured position (signed fixed
//            point). Each request yields exactly one response.
//   rsp_*  : drive_effort in -255..255 plus the forward and reverse duty of the bridge.
//   csr_*  : register writes, index 0..6 (gains, period, inverse period, integral
//            limit, PWM scale); always ready, indexes past the list are dropped.
//            Write only while no request is in flight.
// Timing: rsp_valid rises as the final write-back registers the result, and the
//   sequencer is back in idle in that same cycle; no new request is taken before
//   then. The pace is set by the single 31-bit multiplier, which forms six products,
//   each as two partial products: setup, low, high, accumulate, cap, write-back.
// A request may be accepted while the previous response still waits. If the
//   receiver stalls, the new result holds in its final step until the response
//   register frees up.
// Reset (synchronous) restores the register defaults and clears the integral
//   and the stored measurement.
module pid_position_motor_drive #(
   parameter int DATA_WIDTH = pidpm_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = pidpm_pkg::FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  pidpm_pkg::req_payload_type            req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output pidpm_pkg::rsp_payload_type            rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [pidpm_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [pidpm_pkg::CFG_WIDTH-1:0]       csr_wdata
);
   import pidpm_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Register writes are always accepted and registered without a stall
   assign csr_ready = 1'b1;

   // Sequencer
   pidpm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // Arithmetic and storage
   pidpm_datapath #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid & csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
